### rtl/blr_pkg.sv
package blr_pkg;

   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_ROWS    = 1024;

   localparam int QUEUE_DEPTH = 4;

   localparam int FIELD_W = 16;   // input coordinate width
   localparam int COORD_W = 17;   // working coordinate, room for y + 7
   localparam int SPAN_W  = 16;   // |dx| and |dy|
   localparam int ERR_W   = 19;   // Bresenham error term
   localparam int CFG_W   = 11;
   localparam int BYTE_BITS = 8;
   localparam int ROW_CNT_W = $clog2(BYTE_BITS);
   localparam logic [ROW_CNT_W-1:0] LAST_ROW = ROW_CNT_W'(BYTE_BITS - 1);

   localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd743;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd557;

   localparam logic [1:0] KIND_MOVE = 2'd0;
   localparam logic [1:0] KIND_DRAW = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic {
      OP_LINE,
      OP_READ
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINE,
      ST_READ,
      ST_FIN
   } back_state_type;

   // one job handed from the front end to the back end
   typedef struct packed {
      op_type                     op;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic                       x_major;
      logic                       sx_neg;
      logic                       sy_neg;
      logic [SPAN_W-1:0]          count;
      logic signed [ERR_W-1:0]    err;
      logic signed [ERR_W-1:0]    inc_diag;
      logic signed [ERR_W-1:0]    inc_axis;
   } job_type;

endpackage

### rtl/blr_ram.sv
module blr_ram
   import blr_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/blr_queue.sv
module blr_queue
   import blr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("job pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("job popped from empty queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

### rtl/blr_front.sv
module blr_front
   import blr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_kind,
   input  logic [FIELD_W-1:0]  req_x_coord,
   input  logic [FIELD_W-1:0]  req_y_coord,
   input  logic                clearing,
   input  logic                queue_full,
   output logic                queue_push,
   output job_type             queue_job
);

   logic                       accept;
   logic                       stage_valid_ff, stage_valid_in;
   op_type                     stage_op_ff, stage_op_in;
   logic signed [COORD_W-1:0]  stage_x_ff, stage_x_in;
   logic signed [COORD_W-1:0]  stage_y_ff, stage_y_in;
   logic [SPAN_W-1:0]          stage_hx_ff, stage_hx_in;
   logic [SPAN_W-1:0]          stage_hy_ff, stage_hy_in;
   logic                       stage_sx_neg_ff, stage_sx_neg_in;
   logic                       stage_sy_neg_ff, stage_sy_neg_in;
   logic [FIELD_W-1:0]         pen_x_ff, pen_x_in;
   logic [FIELD_W-1:0]         pen_y_ff, pen_y_in;

   logic signed [COORD_W-1:0]  tx, ty, px, py, dx, dy;
   logic [COORD_W-1:0]         ndx, ndy;
   logic [SPAN_W-1:0]          hmaj, hmin;
   logic                       x_major;

   assign busy       = clearing || (stage_valid_ff && queue_full);
   assign accept     = start && !busy;
   assign queue_push = stage_valid_ff && !queue_full;

   // stage one: spans and directions from the pen
   always_comb begin
      tx  = {req_x_coord[FIELD_W-1], req_x_coord};
      ty  = {req_y_coord[FIELD_W-1], req_y_coord};
      px  = {pen_x_ff[FIELD_W-1], pen_x_ff};
      py  = {pen_y_ff[FIELD_W-1], pen_y_ff};
      dx  = tx - px;
      dy  = ty - py;
      ndx = -dx;
      ndy = -dy;

      pen_x_in        = pen_x_ff;
      pen_y_in        = pen_y_ff;
      stage_valid_in  = queue_push ? 1'b0 : stage_valid_ff;
      stage_op_in     = stage_op_ff;
      stage_x_in      = stage_x_ff;
      stage_y_in      = stage_y_ff;
      stage_hx_in     = stage_hx_ff;
      stage_hy_in     = stage_hy_ff;
      stage_sx_neg_in = stage_sx_neg_ff;
      stage_sy_neg_in = stage_sy_neg_ff;

      if (accept) begin
         case (req_kind)
            KIND_MOVE: begin
               pen_x_in = req_x_coord;
               pen_y_in = req_y_coord;
            end
            KIND_DRAW: begin
               pen_x_in        = req_x_coord;
               pen_y_in        = req_y_coord;
               stage_valid_in  = 1'b1;
               stage_op_in     = OP_LINE;
               stage_x_in      = px;
               stage_y_in      = py;
               stage_hx_in     = dx[COORD_W-1] ? ndx[SPAN_W-1:0] : dx[SPAN_W-1:0];
               stage_hy_in     = dy[COORD_W-1] ? ndy[SPAN_W-1:0] : dy[SPAN_W-1:0];
               stage_sx_neg_in = dx[COORD_W-1] || (dx == '0);
               stage_sy_neg_in = dy[COORD_W-1] || (dy == '0);
            end
            KIND_READ: begin
               stage_valid_in = 1'b1;
               stage_op_in    = OP_READ;
               stage_x_in     = tx;
               stage_y_in     = ty;
            end
            default: begin
               // unused kind: drop
            end
         endcase
      end
   end

   // stage two: axis choice and error terms
   always_comb begin
      x_major = (stage_hx_ff > stage_hy_ff);
      hmaj    = x_major ? stage_hx_ff : stage_hy_ff;
      hmin    = x_major ? stage_hy_ff : stage_hx_ff;

      queue_job.op       = stage_op_ff;
      queue_job.x        = stage_x_ff;
      queue_job.y        = stage_y_ff;
      queue_job.x_major  = x_major;
      queue_job.sx_neg   = stage_sx_neg_ff;
      queue_job.sy_neg   = stage_sy_neg_ff;
      queue_job.count    = hmaj;
      queue_job.err      = $signed({2'b00, hmin, 1'b0}) - $signed({3'b000, hmaj});
      queue_job.inc_diag = $signed({2'b00, hmin, 1'b0}) - $signed({2'b00, hmaj, 1'b0});
      queue_job.inc_axis = $signed({2'b00, hmin, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         pen_x_ff       <= '0;
         pen_y_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         pen_x_ff       <= pen_x_in;
         pen_y_ff       <= pen_y_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_op_ff     <= stage_op_in;
      stage_x_ff      <= stage_x_in;
      stage_y_ff      <= stage_y_in;
      stage_hx_ff     <= stage_hx_in;
      stage_hy_ff     <= stage_hy_in;
      stage_sx_neg_ff <= stage_sx_neg_in;
      stage_sy_neg_ff <= stage_sy_neg_in;
   end

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy)
      else $error("item could be taken during clearing pass");

endmodule

### rtl/blr_back.sv
module blr_back
   import blr_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic                                  csr_index,
   input  logic [CFG_W-1:0]                      csr_data,
   input  logic                                  queue_empty,
   input  job_type                               queue_job,
   output logic                                  queue_pop,
   output logic                                  clearing,
   output logic                                  ram_wr_en,
   output logic [$clog2(MAX_COLUMNS)+$clog2(MAX_ROWS)-1:0] ram_wr_addr,
   output logic                                  ram_wr_data,
   output logic [$clog2(MAX_COLUMNS)+$clog2(MAX_ROWS)-1:0] ram_rd_addr,
   input  logic                                  ram_rd_data,
   output logic                                  rsp_valid,
   output logic [BYTE_BITS-1:0]                  rsp_column_byte
);

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int ADDR_W = COL_W + ROW_W;
   localparam logic [FIELD_W-1:0] MAX_COL_LIM = FIELD_W'(MAX_COLUMNS);
   localparam logic [FIELD_W-1:0] MAX_ROW_LIM = FIELD_W'(MAX_ROWS);

   back_state_type             state_ff, state_in;
   logic [CFG_W-1:0]           width_ff, width_in;
   logic [CFG_W-1:0]           height_ff, height_in;
   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic signed [COORD_W-1:0]  cur_x_ff, cur_x_in;
   logic signed [COORD_W-1:0]  cur_y_ff, cur_y_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [ERR_W-1:0]    inc_diag_ff, inc_diag_in;
   logic signed [ERR_W-1:0]    inc_axis_ff, inc_axis_in;
   logic                       x_major_ff, x_major_in;
   logic                       sx_neg_ff, sx_neg_in;
   logic                       sy_neg_ff, sy_neg_in;
   logic [SPAN_W-1:0]          count_ff, count_in;
   logic [ROW_CNT_W-1:0]       row_ff, row_in;
   logic                       hit_ff, hit_in;
   logic [BYTE_BITS-2:0]       bits_ff, bits_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0]       rsp_byte_ff, rsp_byte_in;

   logic [FIELD_W-1:0]         eff_w, eff_h;
   logic                       pix_hit;
   logic [ADDR_W-1:0]          pix_addr;
   logic                       err_pos;
   logic                       got_bit;
   logic signed [COORD_W-1:0]  step_x, step_y;

   // pixel under the cursor, clipped to the programmed size
   always_comb begin
      eff_w = ({5'b0, width_ff} < MAX_COL_LIM) ? {5'b0, width_ff} : MAX_COL_LIM;
      eff_h = ({5'b0, height_ff} < MAX_ROW_LIM) ? {5'b0, height_ff} : MAX_ROW_LIM;
      pix_hit = !cur_x_ff[COORD_W-1] && !cur_y_ff[COORD_W-1]
                && (cur_x_ff[FIELD_W-1:0] < eff_w) && (cur_y_ff[FIELD_W-1:0] < eff_h);
      pix_addr = {cur_y_ff[ROW_W-1:0], cur_x_ff[COL_W-1:0]};
      err_pos  = !err_ff[ERR_W-1] && (err_ff != '0);
      got_bit  = ram_rd_data && hit_ff;
      step_x   = sx_neg_ff ? -COORD_W'(1) : COORD_W'(1);
      step_y   = sy_neg_ff ? -COORD_W'(1) : COORD_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = (queue_job.op == OP_LINE) ? ST_LINE : ST_READ;
            end
         end
         ST_LINE: begin
            if (count_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (row_ff == LAST_ROW) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs toward queue and memory
   always_comb begin
      queue_pop   = 1'b0;
      clearing    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pix_addr;
      ram_wr_data = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = 1'b0;
         end
         ST_IDLE: queue_pop = !queue_empty;
         ST_LINE: ram_wr_en = pix_hit;
         default: ;
      endcase
   end

   assign ram_rd_addr = pix_addr;

   // datapath
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      clr_addr_in  = clr_addr_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      err_in       = err_ff;
      inc_diag_in  = inc_diag_ff;
      inc_axis_in  = inc_axis_ff;
      x_major_in   = x_major_ff;
      sx_neg_in    = sx_neg_ff;
      sy_neg_in    = sy_neg_ff;
      count_in     = count_ff;
      row_in       = row_ff;
      hit_in       = hit_ff;
      bits_in      = bits_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in  = rsp_byte_ff;

      if (csr_write) begin
         if (csr_index == CSR_WIDTH) begin
            width_in = csr_data;
         end else begin
            height_in = csr_data;
         end
      end

      case (state_ff)
         ST_CLEAR: clr_addr_in = clr_addr_ff + 1'b1;
         ST_IDLE: begin
            cur_x_in    = queue_job.x;
            cur_y_in    = queue_job.y;
            err_in      = queue_job.err;
            inc_diag_in = queue_job.inc_diag;
            inc_axis_in = queue_job.inc_axis;
            x_major_in  = queue_job.x_major;
            sx_neg_in   = queue_job.sx_neg;
            sy_neg_in   = queue_job.sy_neg;
            count_in    = queue_job.count;
            row_in      = '0;
         end
         ST_LINE: begin
            count_in = count_ff - 1'b1;
            // major axis always advances, minor one only on a positive error
            if (x_major_ff) begin
               cur_x_in = cur_x_ff + step_x;
               if (err_pos) begin
                  cur_y_in = cur_y_ff + step_y;
               end
            end else begin
               cur_y_in = cur_y_ff + step_y;
               if (err_pos) begin
                  cur_x_in = cur_x_ff + step_x;
               end
            end
            err_in = err_pos ? err_ff + inc_diag_ff : err_ff + inc_axis_ff;
         end
         ST_READ: begin
            // issue row k now, take row k-1 from the memory
            hit_in   = pix_hit;
            cur_y_in = cur_y_ff + COORD_W'(1);
            row_in   = row_ff + 1'b1;
            if (row_ff != '0) begin
               bits_in = {got_bit, bits_ff[BYTE_BITS-2:1]};
            end
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = {got_bit, bits_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         width_ff     <= RESET_WIDTH;
         height_ff    <= RESET_HEIGHT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      err_ff      <= err_in;
      inc_diag_ff <= inc_diag_in;
      inc_axis_ff <= inc_axis_in;
      x_major_ff  <= x_major_in;
      sx_neg_ff   <= sx_neg_in;
      sy_neg_ff   <= sy_neg_in;
      count_ff    <= count_in;
      row_ff      <= row_in;
      hit_ff      <= hit_in;
      bits_ff     <= bits_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_byte = rsp_byte_ff;

   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_FIN))
      else $error("result strobe without a finished read");

   a_line_counts_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINE && count_ff != '0)
      |=> (state_ff == ST_LINE && count_ff == $past(count_ff) - 1'b1))
      else $error("line walk skipped or repeated a pixel");

endmodule

### rtl/bitmap_line_rasterizer.sv
// One-bit raster with a pen. After reset a clearing pass zeroes the pixel memory, one
// pixel per cycle, all 2^(clog2(MAX_COLUMNS)+clog2(MAX_ROWS)) pixels (1,048,576 at the
// defaults); busy stays high through it. An item is taken when start is high and busy
// low. A move updates the pen and gives no result. A draw walks the line one pixel per
// cycle through the single-write pixel memory, max(|dx|,|dy|)+1 pixels in all. A read
// fetches its eight rows one per cycle from the memory's read port and puts the byte on
// rsp_column_byte with a one-cycle rsp_valid strobe; the receiver must take it then, it
// is never held. Up to four classified items wait in a queue ahead of the pixel engine,
// so apart from the clearing pass busy rises only when that queue is full. Change the
// size registers only while no item is in flight.
module bitmap_line_rasterizer
   import blr_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_kind,
   input  logic [FIELD_W-1:0]   req_x_coord,
   input  logic [FIELD_W-1:0]   req_y_coord,
   output logic                 rsp_valid,
   output logic [BYTE_BITS-1:0] rsp_column_byte,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int ADDR_W = $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS);

   logic              clearing;
   logic              queue_full;
   logic              queue_empty;
   logic              queue_push;
   logic              queue_pop;
   job_type           push_job;
   job_type           head_job;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic              ram_rd_data;

   blr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .clearing    (clearing),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_job   (push_job)
   );

   blr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   blr_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .queue_empty     (queue_empty),
      .queue_job       (head_job),
      .queue_pop       (queue_pop),
      .clearing        (clearing),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_column_byte (rsp_column_byte)
   );

   blr_ram #(
      .WIDTH (1),
      .DEPTH (2 ** ADDR_W)
   ) u_pixels (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
